/* rtl/sbt_pkg.sv */
// Shared types, character codes and helper functions of the source byte tokenizer.
package sbt_pkg;

  localparam int unsigned POS_W   = 21;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned OLEN_W  = 7;

  localparam logic [POS_W-1:0]  POS_ONE   = 21'd1;
  localparam logic [POS_W-1:0]  POS_LIMIT = 21'd1048577;
  localparam logic [LEN_W-1:0]  MAX_TOKEN = 8'd128;
  localparam logic [LEN_W-1:0]  LEN_CAP   = 8'd127;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [KIND_W-1:0] KIND_EOF    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_INT    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_STRING = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd7;
  localparam logic [KIND_W-1:0] KIND_COLON  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd9;
  localparam logic [KIND_W-1:0] KIND_EQUAL  = 4'd10;
  localparam logic [KIND_W-1:0] KIND_DOT    = 4'd11;
  localparam logic [KIND_W-1:0] KIND_ARROW  = 4'd12;

  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NEWLINE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_ESCAPE   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNTERM   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_CHAR     = 3'd5;

  typedef struct packed {
    logic              is_zero;
    logic              is_space;
    logic              is_nl;
    logic              is_alpha;
    logic              is_digit;
    logic              is_hash;
    logic              is_minus;
    logic              is_gt;
    logic              is_dquote;
    logic              is_squote;
    logic              is_bslash;
    logic [KIND_W-1:0] punct;
  } class_t;

  typedef struct packed {
    logic [7:0] ch;
    class_t     cls;
  } word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  error;
    logic [POS_W-1:0]  start_line;
    logic [POS_W-1:0]  start_column;
    logic [OLEN_W-1:0] length;
    logic [7:0]        bad_char;
    logic              last;
  } result_t;

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    begin
      unique case (c)
        CH_LPAREN: k = KIND_LPAREN;
        CH_RPAREN: k = KIND_RPAREN;
        CH_LBRACE: k = KIND_LBRACE;
        CH_RBRACE: k = KIND_RBRACE;
        CH_COLON:  k = KIND_COLON;
        CH_COMMA:  k = KIND_COMMA;
        CH_EQUAL:  k = KIND_EQUAL;
        CH_DOT:    k = KIND_DOT;
        default:   k = KIND_EOF;
      endcase
      return k;
    end
  endfunction

  function automatic logic [OLEN_W-1:0] out_len(input logic [LEN_W-1:0] len);
    return (len > LEN_CAP) ? LEN_CAP[OLEN_W-1:0] : len[OLEN_W-1:0];
  endfunction

endpackage

/* rtl/sbt_front.sv */
// Input side: accepts source bytes and classifies each one for the token engine.
module sbt_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_ch,
  input  logic          q_full,
  output logic          q_push,
  output sbt_pkg::word_t q_word
);
  import sbt_pkg::*;

  class_t cls;

  always_comb begin
    cls.is_zero   = (in_ch == CH_NUL);
    cls.is_space  = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
    cls.is_nl     = (in_ch == CH_NL);
    cls.is_alpha  = ((in_ch >= CH_LA) && (in_ch <= CH_LZ)) ||
                    ((in_ch >= CH_UA) && (in_ch <= CH_UZ)) || (in_ch == CH_USCORE);
    cls.is_digit  = (in_ch >= CH_0) && (in_ch <= CH_9);
    cls.is_hash   = (in_ch == CH_HASH);
    cls.is_minus  = (in_ch == CH_MINUS);
    cls.is_gt     = (in_ch == CH_GT);
    cls.is_dquote = (in_ch == CH_DQUOTE);
    cls.is_squote = (in_ch == CH_SQUOTE);
    cls.is_bslash = (in_ch == CH_BSLASH);
    cls.punct     = punct_kind(in_ch);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_word   = '{ch: in_ch, cls: cls};

endmodule

/* rtl/sbt_fifo.sv */
// Four-entry queue of classified bytes between the input side and the token engine.
module sbt_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbt_pkg::word_t push_word,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sbt_pkg::word_t head_word
);
  import sbt_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  word_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_pop;

  assign full       = (count_r == (AW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_word  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/sbt_back.sv */
// Token engine: scanner state machine, position tracking and the result registers.
module sbt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  sbt_pkg::word_t               head_word,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sbt_pkg::result_t             out_res
);
  import sbt_pkg::*;

  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_COMMENT = 4'd1;
  localparam logic [3:0] MODE_IDENT   = 4'd2;
  localparam logic [3:0] MODE_INT     = 4'd3;
  localparam logic [3:0] MODE_MINUS   = 4'd4;
  localparam logic [3:0] MODE_STRING  = 4'd5;
  localparam logic [3:0] MODE_ESCAPE  = 4'd6;
  localparam logic [3:0] MODE_DONE    = 4'd7;
  localparam logic [3:0] MODE_FAILED  = 4'd8;

  logic [3:0]       mode_r, mode_nxt;
  logic             qs_r, qs_nxt;
  logic [POS_W-1:0] cl_r, cl_nxt, cc_r, cc_nxt, tl_r, tl_nxt, tc_r, tc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             out_valid_r, pend_valid_r;
  result_t          out_r, pend_r;
  result_t          rs [2];
  logic [1:0]       cnt;
  logic             out_free, take, do_idle;
  logic [7:0]       c;
  class_t           k;

  assign out_free  = !out_valid_r || !out_stall;
  assign take      = head_valid && !pend_valid_r && out_free;
  assign pop       = take;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign c         = head_word.ch;
  assign k         = head_word.cls;

  always_comb begin
    mode_nxt = mode_r;
    qs_nxt   = qs_r;
    cl_nxt   = cl_r;
    cc_nxt   = cc_r;
    tl_nxt   = tl_r;
    tc_nxt   = tc_r;
    len_nxt  = len_r;
    rs[0]    = '0;
    rs[1]    = '0;
    cnt      = 2'd0;
    do_idle  = 1'b0;

    unique case (mode_r) inside
      MODE_IDLE: begin
        do_idle = 1'b1;
      end
      MODE_COMMENT: begin
        if (k.is_zero || k.is_nl) begin
          mode_nxt = MODE_IDLE;
          do_idle  = 1'b1;
        end else if (cc_nxt < POS_LIMIT) begin
          cc_nxt = cc_nxt + POS_ONE;
        end
      end
      MODE_IDENT, MODE_INT: begin
        if (k.is_digit || ((mode_r == MODE_IDENT) && k.is_alpha)) begin
          if (len_nxt < MAX_TOKEN) len_nxt = len_nxt + 1'b1;
          if (cc_nxt < POS_LIMIT) cc_nxt = cc_nxt + POS_ONE;
        end else begin
          rs[0].kind         = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_INT;
          rs[0].start_line   = tl_nxt;
          rs[0].start_column = tc_nxt;
          rs[0].length       = out_len(len_nxt);
          cnt                = 2'd1;
          if (len_nxt >= MAX_TOKEN) begin
            rs[0].error = ERR_TOO_LONG;
            mode_nxt    = MODE_FAILED;
          end else begin
            mode_nxt = MODE_IDLE;
            do_idle  = 1'b1;
          end
        end
      end
      MODE_MINUS: begin
        if (k.is_digit || k.is_gt) begin
          if (len_nxt < MAX_TOKEN) len_nxt = len_nxt + 1'b1;
          if (cc_nxt < POS_LIMIT) cc_nxt = cc_nxt + POS_ONE;
          if (k.is_digit) begin
            mode_nxt = MODE_INT;
          end else begin
            mode_nxt           = MODE_IDLE;
            rs[0].kind         = KIND_ARROW;
            rs[0].start_line   = tl_nxt;
            rs[0].start_column = tc_nxt;
            rs[0].length       = out_len(len_nxt);
            cnt                = 2'd1;
          end
        end else begin
          len_nxt            = LEN_W'(1);
          mode_nxt           = MODE_FAILED;
          rs[0].kind         = KIND_EOF;
          rs[0].error        = ERR_CHAR;
          rs[0].bad_char     = CH_MINUS;
          rs[0].start_line   = tl_nxt;
          rs[0].start_column = tc_nxt;
          rs[0].length       = out_len(len_nxt);
          cnt                = 2'd1;
        end
      end
      MODE_STRING, MODE_ESCAPE: begin
        rs[0].kind         = KIND_STRING;
        rs[0].start_line   = tl_nxt;
        rs[0].start_column = tc_nxt;
        rs[0].length       = out_len(len_nxt);
        if (k.is_zero || k.is_nl) begin
          mode_nxt = MODE_FAILED;
          cnt      = 2'd1;
          if (mode_r == MODE_ESCAPE) rs[0].error = ERR_ESCAPE;
          else if (k.is_zero)        rs[0].error = ERR_UNTERM;
          else                       rs[0].error = ERR_NEWLINE;
        end else begin
          if (len_nxt < MAX_TOKEN) len_nxt = len_nxt + 1'b1;
          if (cc_nxt < POS_LIMIT) cc_nxt = cc_nxt + POS_ONE;
          rs[0].length = out_len(len_nxt);
          if (mode_r == MODE_ESCAPE) begin
            mode_nxt = MODE_STRING;
          end else if (k.is_bslash) begin
            mode_nxt = MODE_ESCAPE;
          end else if ((qs_r && k.is_squote) || (!qs_r && k.is_dquote)) begin
            cnt = 2'd1;
            if (len_nxt >= MAX_TOKEN) begin
              rs[0].error = ERR_TOO_LONG;
              mode_nxt    = MODE_FAILED;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (do_idle) begin
      rs[cnt[0]]     = '0;
      if (k.is_zero) begin
        tl_nxt                    = cl_nxt;
        tc_nxt                    = cc_nxt;
        len_nxt                   = '0;
        mode_nxt                  = MODE_DONE;
        rs[cnt[0]].kind           = KIND_EOF;
        rs[cnt[0]].start_line     = tl_nxt;
        rs[cnt[0]].start_column   = tc_nxt;
        cnt                       = cnt + 2'd1;
      end else if (k.is_space || k.is_hash) begin
        if (k.is_hash) mode_nxt = MODE_COMMENT;
        if (k.is_nl) begin
          if (cl_nxt < POS_LIMIT) cl_nxt = cl_nxt + POS_ONE;
          cc_nxt = POS_ONE;
        end else if (cc_nxt < POS_LIMIT) begin
          cc_nxt = cc_nxt + POS_ONE;
        end
      end else begin
        tl_nxt  = cl_nxt;
        tc_nxt  = cc_nxt;
        len_nxt = LEN_W'(1);
        if (cc_nxt < POS_LIMIT) cc_nxt = cc_nxt + POS_ONE;
        rs[cnt[0]].start_line   = tl_nxt;
        rs[cnt[0]].start_column = tc_nxt;
        rs[cnt[0]].length       = out_len(len_nxt);
        if (k.is_alpha) begin
          mode_nxt = MODE_IDENT;
        end else if (k.is_digit) begin
          mode_nxt = MODE_INT;
        end else if (k.is_minus) begin
          mode_nxt = MODE_MINUS;
        end else if (k.is_dquote || k.is_squote) begin
          qs_nxt   = k.is_squote;
          mode_nxt = MODE_STRING;
        end else if (k.punct != KIND_EOF) begin
          rs[cnt[0]].kind = k.punct;
          cnt             = cnt + 2'd1;
        end else begin
          rs[cnt[0]].error    = ERR_CHAR;
          rs[cnt[0]].bad_char = c;
          mode_nxt            = MODE_FAILED;
          cnt                 = cnt + 2'd1;
        end
      end
    end

    if (cnt == 2'd1) rs[0].last = 1'b1;
    if (cnt == 2'd2) rs[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      qs_r   <= 1'b0;
      cl_r   <= POS_ONE;
      cc_r   <= POS_ONE;
      tl_r   <= POS_ONE;
      tc_r   <= POS_ONE;
      len_r  <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      qs_r   <= qs_nxt;
      cl_r   <= cl_nxt;
      cc_r   <= cc_nxt;
      tl_r   <= tl_nxt;
      tc_r   <= tc_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (take && (cnt != 2'd0)) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= (cnt == 2'd2);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid_r) begin
        out_r <= pend_r;
      end else if (take && (cnt != 2'd0)) begin
        out_r  <= rs[0];
        pend_r <= rs[1];
      end
    end
  end

endmodule

/* rtl/source_byte_tokenizer_unit.sv */
// Top level of the source byte tokenizer: input classifier, byte queue and token engine.
//
//   Channel | Direction | Ports
//   --------+-----------+-----------------------------------------------------------
//   in      | sink      | in_valid, in_stall, in_ch
//   out     | source    | out_valid, out_stall, out_kind, out_error, out_start_line,
//           |           | out_start_column, out_length, out_bad_char, out_last
//
// One byte is taken per cycle while the output is free; a byte with two result words
// stalls the next, as one result word per free cycle enters the output register.
// A four-entry queue sits between the classifier and the token engine.
// Reset is synchronous; no clearing pass follows.
// A stalled output holds its word, and the input stalls only when the queue is full.
module source_byte_tokenizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_ch,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbt_pkg::KIND_W-1:0]  out_kind,
  output logic [sbt_pkg::ERR_W-1:0]   out_error,
  output logic [sbt_pkg::POS_W-1:0]   out_start_line,
  output logic [sbt_pkg::POS_W-1:0]   out_start_column,
  output logic [sbt_pkg::OLEN_W-1:0]  out_length,
  output logic [7:0]                  out_bad_char,
  output logic                        out_last
);
  import sbt_pkg::*;

  logic    q_full, q_push, head_valid, pop;
  word_t   q_word, head_word;
  result_t res;

  sbt_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_word)
  );

  sbt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_word  (q_word),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  sbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_kind         = res.kind;
  assign out_error        = res.error;
  assign out_start_line   = res.start_line;
  assign out_start_column = res.start_column;
  assign out_length       = res.length;
  assign out_bad_char     = res.bad_char;
  assign out_last         = res.last;

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the source byte tokenizer: byte stream in, token words checked.
module testbench;
  import sbt_pkg::*;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_IDENT, SCAN_INT, SCAN_MINUS,
    SCAN_STRING, SCAN_ESCAPE, SCAN_DONE, SCAN_FAILED
  } scan_mode_t;

  localparam logic [63:0] SYMBOL_CHARS = {CH_DOT, CH_EQUAL, CH_COMMA, CH_COLON,
                                          CH_RBRACE, CH_LBRACE, CH_RPAREN, CH_LPAREN};
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN       = 32;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_ch = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   out_kind;
  logic [ERR_W-1:0]    out_error;
  logic [POS_W-1:0]    out_start_line;
  logic [POS_W-1:0]    out_start_column;
  logic [OLEN_W-1:0]   out_length;
  logic [7:0]          out_bad_char;
  logic                out_last;

  logic [7:0] source_text[$];
  int         bytes_sent = 0;
  int         stalled_offers = 0;
  bit         hold_active = 1'b0;

  source_byte_tokenizer_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_error        (out_error),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_length       (out_length),
    .out_bad_char     (out_bad_char),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic [KIND_W-1:0] symbol_kind(logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (SYMBOL_CHARS[8*i +: 8] == c) return KIND_LPAREN + i[KIND_W-1:0];
    end
    return KIND_EOF;
  endfunction

  class token_scoreboard;
    scan_mode_t       mode;
    bit               single_quote;
    logic [POS_W-1:0] line_now;
    logic [POS_W-1:0] col_now;
    logic [POS_W-1:0] line_tok;
    logic [POS_W-1:0] col_tok;
    logic [LEN_W-1:0] tok_len;
    result_t          expected_tokens[$];
    int               mismatches;
    int               tokens_checked;
    int               bytes_noted;

    function new();
      mode = SCAN_IDLE;
      single_quote = 1'b0;
      line_now = POS_ONE;
      col_now = POS_ONE;
      line_tok = POS_ONE;
      col_tok = POS_ONE;
      tok_len = '0;
      mismatches = 0;
      tokens_checked = 0;
      bytes_noted = 0;
    endfunction

    function void step_position(logic [7:0] c);
      if (c == CH_NUL) return;
      if (c == CH_NL) begin
        if (line_now < POS_LIMIT) line_now++;
        col_now = POS_ONE;
      end else if (col_now < POS_LIMIT) begin
        col_now++;
      end
    endfunction

    function void lengthen();
      if (tok_len < MAX_TOKEN) tok_len++;
    endfunction

    function void add_token(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err, logic [7:0] bad);
      result_t r;
      r.kind = kind;
      r.error = err;
      r.start_line = line_tok;
      r.start_column = col_tok;
      r.length = (tok_len > LEN_CAP) ? LEN_CAP[OLEN_W-1:0] : tok_len[OLEN_W-1:0];
      r.bad_char = bad;
      r.last = 1'b0;
      expected_tokens.push_back(r);
      if (err != ERR_NONE) mode = SCAN_FAILED;
    endfunction

    function void end_word(logic [KIND_W-1:0] kind);
      if (tok_len >= MAX_TOKEN) begin
        add_token(kind, ERR_TOO_LONG, 8'h00);
      end else begin
        mode = SCAN_IDLE;
        add_token(kind, ERR_NONE, 8'h00);
      end
    endfunction

    function void open_token(logic [7:0] c);
      logic [KIND_W-1:0] sym;
      sym = symbol_kind(c);
      if (c == CH_NUL) begin
        line_tok = line_now;
        col_tok = col_now;
        tok_len = '0;
        mode = SCAN_DONE;
        add_token(KIND_EOF, ERR_NONE, 8'h00);
      end else if (is_blank(c)) begin
        step_position(c);
      end else if (c == CH_HASH) begin
        mode = SCAN_COMMENT;
        step_position(c);
      end else begin
        line_tok = line_now;
        col_tok = col_now;
        tok_len = 8'd1;
        step_position(c);
        if (is_letter(c)) begin
          mode = SCAN_IDENT;
        end else if (is_numeral(c)) begin
          mode = SCAN_INT;
        end else if (c == CH_MINUS) begin
          mode = SCAN_MINUS;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          single_quote = (c == CH_SQUOTE);
          mode = SCAN_STRING;
        end else if (sym != KIND_EOF) begin
          add_token(sym, ERR_NONE, 8'h00);
        end else begin
          add_token(KIND_EOF, ERR_CHAR, c);
        end
      end
    endfunction

    function void note_byte(logic [7:0] c);
      int         queued;
      logic [7:0] quote;
      result_t    r;
      queued = expected_tokens.size();
      bytes_noted++;
      case (mode) inside
        SCAN_IDLE: open_token(c);
        SCAN_COMMENT: begin
          if (c == CH_NUL || c == CH_NL) begin
            mode = SCAN_IDLE;
            open_token(c);
          end else begin
            step_position(c);
          end
        end
        SCAN_IDENT, SCAN_INT: begin
          if (is_numeral(c) || (mode == SCAN_IDENT && is_letter(c))) begin
            lengthen();
            step_position(c);
          end else begin
            end_word(mode == SCAN_IDENT ? KIND_IDENT : KIND_INT);
            if (mode == SCAN_IDLE) open_token(c);
          end
        end
        SCAN_MINUS: begin
          if (is_numeral(c)) begin
            lengthen();
            step_position(c);
            mode = SCAN_INT;
          end else if (c == CH_GT) begin
            lengthen();
            step_position(c);
            mode = SCAN_IDLE;
            add_token(KIND_ARROW, ERR_NONE, 8'h00);
          end else begin
            tok_len = 8'd1;
            add_token(KIND_EOF, ERR_CHAR, CH_MINUS);
          end
        end
        SCAN_STRING: begin
          quote = single_quote ? CH_SQUOTE : CH_DQUOTE;
          if (c == CH_NUL) begin
            add_token(KIND_STRING, ERR_UNTERM, 8'h00);
          end else if (c == CH_NL) begin
            add_token(KIND_STRING, ERR_NEWLINE, 8'h00);
          end else begin
            lengthen();
            step_position(c);
            if (c == CH_BSLASH) mode = SCAN_ESCAPE;
            else if (c == quote) end_word(KIND_STRING);
          end
        end
        SCAN_ESCAPE: begin
          if (c == CH_NUL || c == CH_NL) begin
            add_token(KIND_STRING, ERR_ESCAPE, 8'h00);
          end else begin
            lengthen();
            step_position(c);
            mode = SCAN_STRING;
          end
        end
        default: ;
      endcase
      if (expected_tokens.size() > queued) begin
        r = expected_tokens.pop_back();
        r.last = 1'b1;
        expected_tokens.push_back(r);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_token(result_t got);
      result_t want;
      if (expected_tokens.size() == 0) begin
        $error("Unexpected token word: kind %0d, error %0d at line %0d, column %0d",
               got.kind, got.error, got.start_line, got.start_column);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("error", want.error, got.error);
      compare_field("start_line", want.start_line, got.start_line);
      compare_field("start_column", want.start_column, got.start_column);
      compare_field("length", want.length, got.length);
      compare_field("bad_char", want.bad_char, got.bad_char);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  token_scoreboard board = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        board.check_token({out_kind, out_error, out_start_line, out_start_column,
                           out_length, out_bad_char, out_last});
      end
      if (in_valid && !in_stall) board.note_byte(in_ch);
      if (in_valid && in_stall) stalled_offers++;
    end
  end

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: c = CH_LA + 8'($urandom_range(0, 25));
      1: c = CH_UA + 8'($urandom_range(0, 25));
      default: c = CH_USCORE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] loose_byte(logic [7:0] q);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_NL || c == q || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] pick_quote();
    return ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  function automatic void add_word(bit numeric, int n);
    for (int i = 0; i < n; i++) begin
      if (numeric || (i > 0 && $urandom_range(0, 3) == 0)) source_text.push_back(any_digit());
      else source_text.push_back(any_letter());
    end
  endfunction

  // Pushes the opening quote and a body of exactly the given size; escapes never split.
  function automatic void add_string(int body, logic [7:0] q);
    int i;
    source_text.push_back(q);
    i = 0;
    while (i < body) begin
      if (i + 1 < body && $urandom_range(0, 7) == 0) begin
        source_text.push_back(CH_BSLASH);
        source_text.push_back(loose_byte(CH_NL));
        i += 2;
      end else begin
        source_text.push_back(loose_byte(q));
        i++;
      end
    end
  endfunction

  function automatic void add_separator(bit needed);
    case ($urandom_range(needed ? 1 : 0, 7))
      0: ;
      1, 2: source_text.push_back(CH_SPACE);
      3: source_text.push_back(CH_NL);
      4: source_text.push_back(CH_TAB + 8'($urandom_range(0, 4)));
      5: repeat ($urandom_range(2, 5)) source_text.push_back(CH_SPACE);
      default: begin
        source_text.push_back(CH_HASH);
        repeat ($urandom_range(0, 10)) source_text.push_back(loose_byte(CH_NL));
        source_text.push_back(CH_NL);
      end
    endcase
  endfunction

  // Returns 1 when the token was an identifier or an integer.
  function automatic bit add_token(bit no_word);
    bit         rare;
    logic [7:0] q;
    rare = ($urandom_range(0, 49) == 0);
    case ($urandom_range(no_word ? 4 : 0, 9))
      0, 1: begin
        add_word(1'b0, rare ? $urandom_range(100, 127) : $urandom_range(1, 8));
        return 1'b1;
      end
      2: begin
        add_word(1'b1, rare ? $urandom_range(100, 127) : $urandom_range(1, 6));
        return 1'b1;
      end
      3: begin
        source_text.push_back(CH_MINUS);
        add_word(1'b1, rare ? $urandom_range(99, 126) : $urandom_range(1, 5));
        return 1'b1;
      end
      4: begin
        q = pick_quote();
        add_string(rare ? $urandom_range(90, 125) : $urandom_range(0, 10), q);
        source_text.push_back(q);
        return 1'b0;
      end
      5: begin
        source_text.push_back(CH_MINUS);
        source_text.push_back(CH_GT);
        return 1'b0;
      end
      default: begin
        source_text.push_back(SYMBOL_CHARS[8*$urandom_range(0, 7) +: 8]);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string add_ending();
    logic [7:0] q;
    logic [7:0] c;
    q = pick_quote();
    case ($urandom_range(0, 8))
      0: begin
        if ($urandom_range(0, 1) == 1) begin
          source_text.push_back(CH_HASH);
          repeat ($urandom_range(0, 5)) source_text.push_back(loose_byte(CH_NL));
        end
        source_text.push_back(CH_NUL);
        return "the end of source";
      end
      1: begin
        add_word(1'b0, $urandom_range(128, 140));
        source_text.push_back(CH_SPACE);
        return "an over-long identifier";
      end
      2: begin
        add_word(1'b1, $urandom_range(128, 140));
        source_text.push_back(CH_SPACE);
        return "an over-long integer";
      end
      3: begin
        add_string($urandom_range(126, 140), q);
        source_text.push_back(q);
        return "an over-long string";
      end
      4: begin
        add_string($urandom_range(0, 140), q);
        source_text.push_back(CH_NL);
        return "a newline inside a string";
      end
      5: begin
        add_string($urandom_range(0, 10), q);
        source_text.push_back(CH_BSLASH);
        source_text.push_back(($urandom_range(0, 1) == 1) ? CH_NL : CH_NUL);
        return "a broken escape";
      end
      6: begin
        add_string($urandom_range(0, 10), q);
        source_text.push_back(CH_NUL);
        return "an unterminated string";
      end
      7: begin
        do c = 8'($urandom_range(1, 255));
        while (is_blank(c) || is_letter(c) || is_numeral(c) || c == CH_HASH ||
               c == CH_MINUS || c == CH_DQUOTE || c == CH_SQUOTE ||
               symbol_kind(c) != KIND_EOF);
        source_text.push_back(c);
        return "an unexpected character";
      end
      default: begin
        source_text.push_back(CH_MINUS);
        do c = 8'($urandom_range(0, 255)); while (is_numeral(c) || c == CH_GT);
        source_text.push_back(c);
        return "a lone minus sign";
      end
    endcase
  endfunction

  task automatic feed_byte(input logic [7:0] c, input int gap);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_ch <= c;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : result_sink
    int pause;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && bytes_sent >= HOLD_AT) begin
        held = 1'b1;
        hold_active = 1'b1;
        pause = HOLD_CYCLES;
      end else if ((taken / 30) % 4 == 3) begin
        pause = 0;
      end else begin
        pause = $urandom_range(0, 12);
      end
      if (pause > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (pause - 1) @(negedge clk);
      end
      hold_active = 1'b0;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    string opening;
    string ending;
    int    random_start;
    int    gap;
    bit    last_word;
    bit    glued;
    opening = "(){}:,=.->_Z9 -0'\\''#\n";
    for (int i = 0; i < opening.len(); i++) source_text.push_back(opening[i]);
    source_text.push_back(CH_TAB);
    source_text.push_back(8'h0B);
    source_text.push_back(8'h0C);
    source_text.push_back(CH_CR);
    source_text.push_back(CH_DQUOTE);
    source_text.push_back(8'h80);
    source_text.push_back(8'hFF);
    source_text.push_back(CH_DQUOTE);
    random_start = source_text.size();
    glued = 1'b0;
    while (source_text.size() < random_start + 400) begin
      last_word = add_token(glued);
      glued = 1'b0;
      if (last_word) begin
        if ($urandom_range(0, 2) == 0) glued = 1'b1;
        else add_separator(1'b1);
      end else begin
        add_separator(1'b0);
      end
    end
    add_separator(1'b1);
    ending = add_ending();
    // Everything after the final word must be ignored by the block.
    repeat (8) source_text.push_back(8'($urandom_range(0, 255)));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    foreach (source_text[i]) begin
      if (hold_active || (i / 50) % 4 == 3) gap = 0;
      else gap = $urandom_range(0, 12);
      feed_byte(source_text[i], gap);
      bytes_sent++;
    end
    @(negedge clk) in_valid <= 1'b0;
    while (board.expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Checked %0d token words from %0d source bytes; the source ended with %s.",
             board.tokens_checked, board.bytes_noted, ending);
    $display("The input was held back by the block on %0d offered cycles.", stalled_offers);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Timed out with %0d token words still expected.", board.expected_tokens.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
